/* rtl/brp_pkg.sv */
// Shared types, constants and helpers of the byte range parser.
package brp_pkg;

  localparam int unsigned LEN_BITS_DEF = 48;
  localparam int unsigned PREFIX_LEN   = 6;

  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    PH_PREFIX = 2'd0,
    PH_START  = 2'd1,
    PH_END    = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ST_EMPTY  = 2'd0,
    ST_DIGITS = 2'd1,
    ST_TAIL   = 2'd2,
    ST_BAD    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OUT_FULL  = 2'd0,
    OUT_RANGE = 2'd1,
    OUT_UNSAT = 2'd2
  } outcome_e;

  // Parse summary handed from the scanner to the verdict stage.
  typedef struct packed {
    logic    rejected;
    logic    in_end;
    status_e start_st;
    status_e end_st;
  } brp_snap_t;

  // Expected character of the "bytes=" prefix at a given position.
  function automatic logic [7:0] prefix_char(input logic [2:0] pos);
    logic [7:0] ch;
    unique case (pos)
      3'd0:    ch = 8'h62;  // b
      3'd1:    ch = 8'h79;  // y
      3'd2:    ch = 8'h74;  // t
      3'd3:    ch = 8'h65;  // e
      3'd4:    ch = 8'h73;  // s
      3'd5:    ch = 8'h3d;  // =
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic is_blank(input logic [7:0] ch);
    return (ch == CH_SPACE) || (ch == CH_TAB);
  endfunction

  function automatic logic is_digit(input logic [7:0] ch);
    return (ch >= CH_ZERO) && (ch <= CH_NINE);
  endfunction

endpackage

/* rtl/brp_hdr_if.sv */
// Header character channel: valid, ready and one character transaction.
interface brp_hdr_if #(
  parameter int unsigned LenBits = brp_pkg::LEN_BITS_DEF
);
  logic               valid;
  logic               ready;
  logic [7:0]         header_char;
  logic [LenBits-1:0] resource_length;
  logic               is_last_char;

  modport source (
    output valid, header_char, resource_length, is_last_char,
    input  ready
  );
  modport sink (
    input  valid, header_char, resource_length, is_last_char,
    output ready
  );
endinterface

/* rtl/brp_vrd_if.sv */
// Verdict channel: valid, ready and one verdict transaction.
interface brp_vrd_if #(
  parameter int unsigned LenBits = brp_pkg::LEN_BITS_DEF
);
  logic               valid;
  logic               ready;
  logic [1:0]         outcome;
  logic [LenBits-1:0] first_byte;
  logic [LenBits-1:0] last_byte;

  modport source (
    output valid, outcome, first_byte, last_byte,
    input  ready
  );
  modport sink (
    input  valid, outcome, first_byte, last_byte,
    output ready
  );
endinterface

/* rtl/brp_scan.sv */
// Character scanner: prefix match, number accumulation and parse snapshot.
module brp_scan #(
  parameter int unsigned LenBits = brp_pkg::LEN_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                valid_i,
  input  logic [7:0]          char_i,
  input  logic [LenBits-1:0]  len_i,
  input  logic                last_i,
  output logic                snap_valid_o,
  output brp_pkg::brp_snap_t  snap_o,
  output logic [LenBits-1:0]  start_o,
  output logic [LenBits-1:0]  end_o,
  output logic [LenBits-1:0]  len_o
);

  localparam int unsigned AccBits = LenBits + 4;

  brp_pkg::phase_e  phase_q, phase_d;
  brp_pkg::status_e start_st_q, start_st_d;
  brp_pkg::status_e end_st_q, end_st_d;
  logic [2:0]         pos_q, pos_d;
  logic               rej_q, rej_d;
  logic [LenBits-1:0] start_q, start_d;
  logic [LenBits-1:0] end_q, end_d;

  logic [AccBits-1:0] start_mac, end_mac;
  logic [AccBits-1:0] digit_ext;
  logic               start_ovf, end_ovf;
  logic               prefix_hit;
  logic               do_feed_start, do_feed_end;
  logic               take;

  logic               snap_valid_q;
  brp_pkg::brp_snap_t snap_q;
  logic [LenBits-1:0] snap_start_q, snap_end_q, snap_len_q;

  // One decimal step for a field: status after one more character.
  function automatic brp_pkg::status_e feed(input brp_pkg::status_e st,
                                            input logic [7:0] ch,
                                            input logic ovf);
    brp_pkg::status_e nx;
    nx = brp_pkg::ST_BAD;
    if (st == brp_pkg::ST_BAD) begin
      nx = brp_pkg::ST_BAD;
    end else if (brp_pkg::is_blank(ch)) begin
      nx = (st == brp_pkg::ST_EMPTY) ? brp_pkg::ST_EMPTY : brp_pkg::ST_TAIL;
    end else if (brp_pkg::is_digit(ch)) begin
      nx = (st == brp_pkg::ST_TAIL || ovf) ? brp_pkg::ST_BAD : brp_pkg::ST_DIGITS;
    end
    return nx;
  endfunction

  assign take       = adv_i && valid_i;
  assign digit_ext  = {{LenBits{1'b0}}, char_i[3:0]};
  assign start_mac  = ({4'b0, start_q} << 3) + ({4'b0, start_q} << 1) + digit_ext;
  assign end_mac    = ({4'b0, end_q} << 3) + ({4'b0, end_q} << 1) + digit_ext;
  assign start_ovf  = |start_mac[AccBits-1:LenBits];
  assign end_ovf    = |end_mac[AccBits-1:LenBits];
  assign prefix_hit = (char_i == brp_pkg::prefix_char(pos_q));

  assign do_feed_start = !rej_q && (phase_q == brp_pkg::PH_START) &&
                         (char_i != brp_pkg::CH_COMMA) && (char_i != brp_pkg::CH_DASH);
  assign do_feed_end   = !rej_q && (phase_q == brp_pkg::PH_END) &&
                         (char_i != brp_pkg::CH_COMMA);

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (!rej_q) begin
      unique case (phase_q)
        brp_pkg::PH_PREFIX: begin
          if (prefix_hit && pos_q == 3'(brp_pkg::PREFIX_LEN - 1)) phase_d = brp_pkg::PH_START;
        end
        brp_pkg::PH_START: begin
          if (char_i == brp_pkg::CH_DASH) phase_d = brp_pkg::PH_END;
        end
        brp_pkg::PH_END: phase_d = brp_pkg::PH_END;
        default: phase_d = brp_pkg::PH_PREFIX;
      endcase
    end
  end

  // Datapath and flags
  always_comb begin
    pos_d      = pos_q;
    rej_d      = rej_q;
    start_d    = start_q;
    end_d      = end_q;
    start_st_d = start_st_q;
    end_st_d   = end_st_q;
    if (!rej_q) begin
      if (phase_q == brp_pkg::PH_PREFIX) begin
        if (prefix_hit) pos_d = pos_q + 3'd1;
        else            rej_d = 1'b1;
      end else if (char_i == brp_pkg::CH_COMMA) begin
        rej_d = 1'b1;
      end
    end
    if (do_feed_start) begin
      start_st_d = feed(start_st_q, char_i, start_ovf);
      if (start_st_d == brp_pkg::ST_BAD) rej_d = 1'b1;
      if (start_st_d == brp_pkg::ST_DIGITS && brp_pkg::is_digit(char_i)) begin
        start_d = start_mac[LenBits-1:0];
      end
    end
    if (do_feed_end) begin
      end_st_d = feed(end_st_q, char_i, end_ovf);
      if (end_st_d == brp_pkg::ST_DIGITS && brp_pkg::is_digit(char_i)) begin
        end_d = end_mac[LenBits-1:0];
      end
    end
  end

  // Parse state: back to reset after the final character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= brp_pkg::PH_PREFIX;
      pos_q      <= 3'd0;
      rej_q      <= 1'b0;
      start_q    <= '0;
      end_q      <= '0;
      start_st_q <= brp_pkg::ST_EMPTY;
      end_st_q   <= brp_pkg::ST_EMPTY;
    end else if (take) begin
      if (last_i) begin
        phase_q    <= brp_pkg::PH_PREFIX;
        pos_q      <= 3'd0;
        rej_q      <= 1'b0;
        start_q    <= '0;
        end_q      <= '0;
        start_st_q <= brp_pkg::ST_EMPTY;
        end_st_q   <= brp_pkg::ST_EMPTY;
      end else begin
        phase_q    <= phase_d;
        pos_q      <= pos_d;
        rej_q      <= rej_d;
        start_q    <= start_d;
        end_q      <= end_d;
        start_st_q <= start_st_d;
        end_st_q   <= end_st_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_valid_q <= 1'b0;
    end else if (adv_i) begin
      snap_valid_q <= valid_i && last_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && last_i) begin
      snap_q.rejected <= rej_d;
      snap_q.in_end   <= (phase_d == brp_pkg::PH_END);
      snap_q.start_st <= start_st_d;
      snap_q.end_st   <= end_st_d;
      snap_start_q    <= start_d;
      snap_end_q      <= end_d;
      snap_len_q      <= len_i;
    end
  end

  assign snap_valid_o = snap_valid_q;
  assign snap_o       = snap_q;
  assign start_o      = snap_start_q;
  assign end_o        = snap_end_q;
  assign len_o        = snap_len_q;

endmodule

/* rtl/brp_judge.sv */
// Verdict stage: range decision from the parse snapshot, into the result register.
module brp_judge #(
  parameter int unsigned LenBits = brp_pkg::LEN_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               snap_valid_i,
  input  brp_pkg::brp_snap_t snap_i,
  input  logic [LenBits-1:0] start_i,
  input  logic [LenBits-1:0] end_i,
  input  logic [LenBits-1:0] len_i,
  output logic               valid_o,
  output logic [1:0]         outcome_o,
  output logic [LenBits-1:0] first_o,
  output logic [LenBits-1:0] last_o
);

  brp_pkg::outcome_e  outcome_d;
  logic [LenBits-1:0] first_d, last_d;
  logic               end_ok, end_ge_len, start_ge_len, end_lt_start;
  logic [LenBits-1:0] len_m1, len_sub_end;

  logic               valid_q;
  logic [1:0]         outcome_q;
  logic [LenBits-1:0] first_q, last_q;

  assign end_ok       = (snap_i.end_st == brp_pkg::ST_DIGITS) ||
                        (snap_i.end_st == brp_pkg::ST_TAIL);
  assign end_ge_len   = (end_i >= len_i);
  assign start_ge_len = (start_i >= len_i);
  assign end_lt_start = (end_i < start_i);
  assign len_m1       = len_i - LenBits'(1);
  assign len_sub_end  = len_i - end_i;

  always_comb begin
    outcome_d = brp_pkg::OUT_FULL;
    first_d   = '0;
    last_d    = '0;
    priority if (snap_i.rejected || !snap_i.in_end) begin
      outcome_d = brp_pkg::OUT_FULL;
    end else if (snap_i.start_st == brp_pkg::ST_EMPTY) begin
      priority if (!end_ok) begin
        outcome_d = brp_pkg::OUT_FULL;
      end else if (end_i == '0 || len_i == '0) begin
        outcome_d = brp_pkg::OUT_UNSAT;
      end else begin
        outcome_d = brp_pkg::OUT_RANGE;
        first_d   = end_ge_len ? '0 : len_sub_end;
        last_d    = len_m1;
      end
    end else if (start_ge_len) begin
      outcome_d = brp_pkg::OUT_UNSAT;
    end else if (snap_i.end_st == brp_pkg::ST_EMPTY) begin
      outcome_d = brp_pkg::OUT_RANGE;
      first_d   = start_i;
      last_d    = len_m1;
    end else if (!end_ok) begin
      outcome_d = brp_pkg::OUT_FULL;
    end else if (!end_ge_len && end_lt_start) begin
      // start is below the length here, so a clamped end never falls short
      outcome_d = brp_pkg::OUT_FULL;
    end else begin
      outcome_d = brp_pkg::OUT_RANGE;
      first_d   = start_i;
      last_d    = end_ge_len ? len_m1 : end_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= snap_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && snap_valid_i) begin
      outcome_q <= outcome_d;
      first_q   <= first_d;
      last_q    <= last_d;
    end
  end

  assign valid_o   = valid_q;
  assign outcome_o = outcome_q;
  assign first_o   = first_q;
  assign last_o    = last_q;

endmodule

/* rtl/http_byte_range_parser_unit.sv */
// Top level of the single byte range parser for HTTP Range headers.
//
// hdr_i takes one header character per transaction, with the resource length
// and a flag on the final character; the length is read only with that final
// character. verdict_o gives one transaction per header: outcome (serve full or
// malformed, satisfiable range, unsatisfiable) and the inclusive byte range,
// which reads zero unless the range is satisfiable.
//
// Pipeline: skid register, input register, scanner (state and snapshot),
// verdict register. One character is taken per cycle while verdict_o is not
// stalled. The final character's transaction passes the input register and the
// scanner snapshot before the verdict register presents it on verdict_o; the
// scanner's one-character state update sets the single-cycle pace.
// Reset clears every valid flag and returns the scanner to prefix matching;
// no clearing pass is needed. When the receiver stalls, the whole pipeline
// holds; one character that arrives in that cycle is parked in the skid
// register and hdr_i.ready drops until it has moved on.
module http_byte_range_parser_unit #(
  parameter int unsigned LenBits = brp_pkg::LEN_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  brp_hdr_if.sink   hdr_i,
  brp_vrd_if.source verdict_o
);

  logic               stall, adv;
  logic               in_take;

  // Skid register
  logic               skid_valid_q;
  logic [7:0]         skid_char_q;
  logic [LenBits-1:0] skid_len_q;
  logic               skid_last_q;

  // Input register
  logic               in_valid_q;
  logic [7:0]         in_char_q;
  logic [LenBits-1:0] in_len_q;
  logic               in_last_q;

  logic               snap_valid;
  brp_pkg::brp_snap_t snap;
  logic [LenBits-1:0] snap_start, snap_end, snap_len;

  // Hold the whole pipeline while a verdict waits for the receiver.
  assign stall   = verdict_o.valid && !verdict_o.ready;
  assign adv     = !stall;
  assign in_take = hdr_i.valid && hdr_i.ready;

  assign hdr_i.ready = !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (adv) skid_valid_q <= 1'b0;
    end else if (in_take && stall) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take && stall) begin
      skid_char_q <= hdr_i.header_char;
      skid_len_q  <= hdr_i.resource_length;
      skid_last_q <= hdr_i.is_last_char;
    end
  end

  // Advance the input register from the skid register first, else from the port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (adv) begin
      in_valid_q <= skid_valid_q || in_take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (skid_valid_q) begin
        in_char_q <= skid_char_q;
        in_len_q  <= skid_len_q;
        in_last_q <= skid_last_q;
      end else begin
        in_char_q <= hdr_i.header_char;
        in_len_q  <= hdr_i.resource_length;
        in_last_q <= hdr_i.is_last_char;
      end
    end
  end

  brp_scan #(
    .LenBits(LenBits)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .valid_i     (in_valid_q),
    .char_i      (in_char_q),
    .len_i       (in_len_q),
    .last_i      (in_last_q),
    .snap_valid_o(snap_valid),
    .snap_o      (snap),
    .start_o     (snap_start),
    .end_o       (snap_end),
    .len_o       (snap_len)
  );

  brp_judge #(
    .LenBits(LenBits)
  ) u_judge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .snap_valid_i(snap_valid),
    .snap_i      (snap),
    .start_i     (snap_start),
    .end_i       (snap_end),
    .len_i       (snap_len),
    .valid_o     (verdict_o.valid),
    .outcome_o   (verdict_o.outcome),
    .first_o     (verdict_o.first_byte),
    .last_o      (verdict_o.last_byte)
  );

endmodule

/* rtl/brp_chk.sv */
// Port-level checks of the byte range parser, bound to its top level.
module brp_chk #(
  parameter int unsigned LenBits = brp_pkg::LEN_BITS_DEF
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               hdr_ready_i,
  input logic               vrd_valid_i,
  input logic               vrd_ready_i,
  input logic [1:0]         vrd_outcome_i,
  input logic [LenBits-1:0] vrd_first_i,
  input logic [LenBits-1:0] vrd_last_i
);

  // A stalled verdict holds its payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vrd_valid_i && !vrd_ready_i |=>
      $stable(vrd_outcome_i) && $stable(vrd_first_i) && $stable(vrd_last_i))
    else $error("verdict payload changed while stalled");

  // Input back-pressure only follows an output stall.
  a_bp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !hdr_ready_i |-> $past(vrd_valid_i && !vrd_ready_i))
    else $error("input not ready without an output stall");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vrd_valid_i |-> vrd_outcome_i != 2'd3)
    else $error("undefined outcome code");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vrd_valid_i && vrd_outcome_i != brp_pkg::OUT_RANGE |->
      vrd_first_i == '0 && vrd_last_i == '0)
    else $error("range bounds set without a satisfiable range");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vrd_valid_i && vrd_outcome_i == brp_pkg::OUT_RANGE |-> vrd_first_i <= vrd_last_i)
    else $error("range first byte beyond last byte");

endmodule

bind http_byte_range_parser_unit brp_chk #(
  .LenBits(LenBits)
) u_brp_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .hdr_ready_i  (hdr_i.ready),
  .vrd_valid_i  (verdict_o.valid),
  .vrd_ready_i  (verdict_o.ready),
  .vrd_outcome_i(verdict_o.outcome),
  .vrd_first_i  (verdict_o.first_byte),
  .vrd_last_i   (verdict_o.last_byte)
);

/* tb/tb_http_byte_range_parser_unit.sv */
// Self-checking testbench of the HTTP single byte range parser, with its own verdict predictor.
module tb_http_byte_range_parser_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import brp_pkg::*;

  localparam int unsigned LW = LEN_BITS_DEF;
  localparam longint unsigned LEN_MAX = (64'd1 << LW) - 64'd1;
  localparam string RANGE_UNIT = "bytes=";
  localparam int unsigned RANDOM_CHARS = 960;

  typedef logic [LW-1:0] len_t;

  // One character transaction as it is offered on the header channel.
  typedef struct {
    logic [7:0] ch;
    len_t       len;
    logic       last;
    bit         hold;  // wait for every outstanding verdict before offering it
  } hdr_char_t;

  typedef struct packed {
    outcome_e outcome;
    len_t     first_byte;
    len_t     last_byte;
  } verdict_t;

  logic clk_i;
  logic rst_ni;

  brp_hdr_if #(.LenBits(LW)) hdr_ch ();
  brp_vrd_if #(.LenBits(LW)) vrd_ch ();

  http_byte_range_parser_unit #(
    .LenBits(LW)
  ) dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .hdr_i    (hdr_ch),
    .verdict_o(vrd_ch)
  );

  hdr_char_t   chars_pending[$];
  verdict_t    verdicts_due[$];
  logic [7:0]  text_q[$];
  int unsigned chars_queued;
  int unsigned chars_taken;
  int unsigned errors;
  int unsigned gap_left;
  int unsigned stall_left;
  bit          calm;

  // Scanner state of the predictor: a copy of what the block keeps per header.
  int unsigned scan_pos;
  phase_e      scan_phase;
  len_t        start_acc;
  len_t        end_acc;
  status_e     start_st;
  status_e     end_st;
  bit          scan_rejected;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Give up long after the slowest legal run could have finished.
  initial begin
    #1_000_000;
    $display("tb_http_byte_range_parser_unit: errors");
    $finish;
  end

  task automatic report(input string what);
    errors++;
    if (errors <= 40) $display("%0t ns: %s", $time, what);
  endtask

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_scan();
    scan_pos      = 0;
    scan_phase    = PH_PREFIX;
    start_acc     = '0;
    end_acc       = '0;
    start_st      = ST_EMPTY;
    end_st        = ST_EMPTY;
    scan_rejected = 1'b0;
  endfunction

  // Advance one decimal field by one character; blanks may only lead or trail.
  function automatic status_e feed_number(input status_e st, inout len_t acc,
                                           input logic [7:0] ch);
    longint unsigned d;
    if (st == ST_BAD) return ST_BAD;
    if (ch == CH_SPACE || ch == CH_TAB) return (st == ST_EMPTY) ? ST_EMPTY : ST_TAIL;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      d = longint'(ch - CH_ZERO);
      if (st == ST_TAIL) return ST_BAD;
      // Refuse anything that would no longer fit the length width.
      if (64'(acc) > (LEN_MAX - d) / 64'd10) return ST_BAD;
      acc = len_t'(64'(acc) * 64'd10 + d);
      return ST_DIGITS;
    end
    return ST_BAD;
  endfunction

  function automatic void scan_char(input logic [7:0] ch);
    if (scan_rejected) return;
    if (scan_phase == PH_PREFIX) begin
      if (scan_pos < PREFIX_LEN && ch == RANGE_UNIT[scan_pos]) begin
        scan_pos++;
        if (scan_pos == PREFIX_LEN) scan_phase = PH_START;
      end else begin
        scan_rejected = 1'b1;
      end
      return;
    end
    // A list of ranges is never honoured: serve the lot.
    if (ch == CH_COMMA) begin
      scan_rejected = 1'b1;
      return;
    end
    if (scan_phase == PH_START) begin
      if (ch == CH_DASH) begin
        scan_phase = PH_END;
        return;
      end
      start_st = feed_number(start_st, start_acc, ch);
      if (start_st == ST_BAD) scan_rejected = 1'b1;
      return;
    end
    // Anything after the first dash, a second dash too, feeds the end text.
    end_st = feed_number(end_st, end_acc, ch);
  endfunction

  function automatic verdict_t rule_on_range(input len_t len);
    verdict_t v;
    len_t     e;
    bit       end_ok;
    v.outcome    = OUT_FULL;
    v.first_byte = '0;
    v.last_byte  = '0;
    end_ok = (end_st == ST_DIGITS) || (end_st == ST_TAIL);
    if (scan_rejected || scan_phase != PH_END) begin
      v.outcome = OUT_FULL;
    end else if (start_st == ST_EMPTY) begin
      // Suffix form: the last N bytes, clipped to the resource.
      if (!end_ok) begin
        v.outcome = OUT_FULL;
      end else if (end_acc == '0 || len == '0) begin
        v.outcome = OUT_UNSAT;
      end else begin
        v.first_byte = (end_acc >= len) ? '0 : len - end_acc;
        v.last_byte  = len - 1'b1;
        v.outcome    = OUT_RANGE;
      end
    end else if (start_acc >= len) begin
      // Unsatisfiable wins before the end text is even looked at.
      v.outcome = OUT_UNSAT;
    end else if (end_st == ST_EMPTY) begin
      v.first_byte = start_acc;
      v.last_byte  = len - 1'b1;
      v.outcome    = OUT_RANGE;
    end else if (!end_ok) begin
      v.outcome = OUT_FULL;
    end else begin
      e = (end_acc >= len) ? len - 1'b1 : end_acc;
      if (e < start_acc) begin
        v.outcome = OUT_FULL;
      end else begin
        v.first_byte = start_acc;
        v.last_byte  = e;
        v.outcome    = OUT_RANGE;
      end
    end
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic len_t rand_len();
    longint unsigned r;
    r = {$urandom(), $urandom()};
    return r[LW-1:0];
  endfunction

  // Mostly back to back, sometimes a short pause, now and then a long one.
  function automatic int unsigned pick_delay();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic put_number(input longint unsigned v);
    put_text($sformatf("%0d", v));
  endtask

  task automatic put_blanks();
    int unsigned n;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (n) text_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
  endtask

  // Turn the text under construction into character transactions; only the
  // final one carries the real length, the others carry junk the block ignores.
  task automatic send_header(input len_t len, input bit hold);
    hdr_char_t c;
    int unsigned n;
    if (text_q.size() == 0) text_q.push_back(RANGE_UNIT[0]);
    n = text_q.size();
    for (int unsigned i = 0; i < n; i++) begin
      c.ch   = text_q[i];
      c.last = (i == n - 1);
      c.len  = c.last ? len : rand_len();
      c.hold = hold && (i == 0);
      chars_pending.push_back(c);
    end
    chars_queued += n;
    text_q.delete();
  endtask

  task automatic send_text(input string s, input len_t len);
    put_text(s);
    send_header(len, 1'b0);
  endtask

  function automatic len_t pick_length();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return len_t'($urandom_range(1, 20));
      2, 3:    return len_t'($urandom_range(1, 5000));
      4, 5:    return rand_len();
      6:       return len_t'(LEN_MAX);
      default: return len_t'($urandom_range(1, 1 << 20));
    endcase
  endfunction

  // Values clustered around the length, so that every comparison is exercised.
  function automatic longint unsigned pick_value(input len_t len);
    longint unsigned l;
    l = 64'(len);
    case ($urandom_range(0, 11))
      0:       return 0;
      1:       return l;
      2:       return (l == 0) ? 0 : l - 1;
      3:       return l + 1;
      6:       return $urandom_range(0, 1000);
      7:       return 64'(rand_len());
      8:       return LEN_MAX;
      9:       return LEN_MAX + 1 + $urandom_range(0, 999);
      default: return 64'(rand_len()) % (l + 1);
    endcase
  endfunction

  // A well-formed single range with random numbers and blanks.
  task automatic build_range(input len_t len);
    int unsigned form;
    form = $urandom_range(0, 9);
    put_text(RANGE_UNIT);
    put_blanks();
    if (form > 1) put_number(pick_value(len));
    put_blanks();
    text_q.push_back(CH_DASH);
    put_blanks();
    if (form != 2) put_number(pick_value(len));
    put_blanks();
  endtask

  // Damage a header in one of several ways, or replace it with noise.
  task automatic build_broken(input len_t len);
    int unsigned pos;
    case ($urandom_range(0, 5))
      0: begin
        repeat ($urandom_range(1, 10)) text_q.push_back($urandom_range(0, 255));
      end
      1: begin
        build_range(len);
        pos = $urandom_range(0, text_q.size() - 1);
        text_q[pos] = $urandom_range(0, 255);
      end
      2: begin
        build_range(len);
        pos = $urandom_range(PREFIX_LEN, text_q.size());
        text_q.insert(pos, CH_COMMA);
      end
      3: begin
        build_range(len);
        pos = $urandom_range(1, text_q.size());
        while (text_q.size() > pos) void'(text_q.pop_back());
      end
      4: begin
        build_range(len);
        pos = $urandom_range(0, PREFIX_LEN - 1);
        text_q[pos] = text_q[pos] ^ 8'h20;
      end
      default: begin
        build_range(len);
        text_q.push_back(CH_DASH);
        put_number($urandom_range(0, 99));
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer pending characters, predict on each accepted transaction
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_ch.valid <= 1'b0;
      gap_left     <= 0;
    end else begin
      if (hdr_ch.valid && hdr_ch.ready) begin
        scan_char(hdr_ch.header_char);
        if (hdr_ch.is_last_char) begin
          verdicts_due.push_back(rule_on_range(hdr_ch.resource_length));
          clear_scan();
        end
        chars_taken++;
        // Switch between idle-free stretches and ragged traffic now and then.
        if (chars_taken % 150 == 0) calm = ($urandom_range(0, 2) == 0);
      end
      if (!hdr_ch.valid || hdr_ch.ready) begin
        if (gap_left != 0) begin
          hdr_ch.valid <= 1'b0;
          gap_left     <= gap_left - 1;
        end else if (chars_pending.size() != 0 &&
                     !(chars_pending[0].hold && verdicts_due.size() != 0)) begin
          hdr_ch.valid           <= 1'b1;
          hdr_ch.header_char     <= chars_pending[0].ch;
          hdr_ch.resource_length <= chars_pending[0].len;
          hdr_ch.is_last_char    <= chars_pending[0].last;
          void'(chars_pending.pop_front());
          gap_left <= pick_delay();
        end else begin
          hdr_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random back-pressure, compare each verdict with the oldest due
  // ---------------------------------------------------------------------------

  task automatic check_verdict();
    verdict_t exp_v;
    if (verdicts_due.size() == 0) begin
      report($sformatf("verdict outcome %0d with none due", vrd_ch.outcome));
      return;
    end
    exp_v = verdicts_due.pop_front();
    if (vrd_ch.outcome !== exp_v.outcome)
      report($sformatf("outcome %0d, want %0d", vrd_ch.outcome, exp_v.outcome));
    if (vrd_ch.first_byte !== exp_v.first_byte)
      report($sformatf("first_byte %0d, want %0d", vrd_ch.first_byte, exp_v.first_byte));
    if (vrd_ch.last_byte !== exp_v.last_byte)
      report($sformatf("last_byte %0d, want %0d", vrd_ch.last_byte, exp_v.last_byte));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vrd_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else begin
      if (vrd_ch.valid && vrd_ch.ready) check_verdict();
      if (stall_left != 0) begin
        vrd_ch.ready <= 1'b0;
        stall_left   <= stall_left - 1;
      end else begin
        vrd_ch.ready <= 1'b1;
        stall_left   <= pick_delay();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned random_base;
    int unsigned headers;
    len_t        len;

    rst_ni                 = 1'b0;
    hdr_ch.valid           = 1'b0;
    hdr_ch.header_char     = '0;
    hdr_ch.resource_length = '0;
    hdr_ch.is_last_char    = 1'b0;
    vrd_ch.ready           = 1'b0;
    chars_queued           = 0;
    chars_taken            = 0;
    errors                 = 0;
    calm                   = 1'b0;
    clear_scan();

    // Directed headers: prefix failures, every verdict and the corner cases.
    send_text("b", 48'd100);                        // too short to hold the prefix
    send_text("bytes=", 48'd100);                   // prefix alone, no dash
    send_text("Bytes=0-1", 48'd100);                // prefix is case sensitive
    send_text("bytes=0-99", 48'd100);
    send_text("bytes=-10", 48'd100);                // last ten bytes
    send_text("bytes=-200", 48'd100);               // suffix longer than the resource
    send_text("bytes=-0", 48'd100);                 // empty suffix
    send_text("bytes=-5", 48'd0);                   // suffix of an empty resource
    send_text("bytes=-", 48'd100);                  // suffix with no number
    send_text("bytes=100-x", 48'd100);              // start past the end beats a bad end
    send_text("bytes=0-", 48'd0);
    send_text("bytes=5-", 48'd100);                 // open end
    send_text("bytes=5-x", 48'd100);                // bad end text
    send_text("bytes=5-1000", 48'd100);             // end clamped
    send_text("bytes=50-10", 48'd100);              // end below start
    send_text("bytes=0-1,2-3", 48'd100);            // list of ranges
    send_text("bytes=12", 48'd100);                 // no dash
    send_text("bytes=1 2-3", 48'd100);              // digit after an inner blank
    send_text("bytes= \t7 \t- \t9\t ", 48'd100);    // blanks trimmed everywhere
    send_text("bytes=1-2-3", 48'd100);              // second dash spoils the end
    send_text("bytes=0-0", 48'd1);
    send_text($sformatf("bytes=%0d-", LEN_MAX - 1), len_t'(LEN_MAX));
    send_text($sformatf("bytes=%0d-", LEN_MAX + 1), len_t'(LEN_MAX));  // start overflows
    send_text($sformatf("bytes=0-%0d", LEN_MAX + 1), len_t'(LEN_MAX)); // end overflows
    send_text($sformatf("bytes=-%0d", LEN_MAX), len_t'(LEN_MAX));
    text_q.push_back(8'h00);
    send_header(len_t'(LEN_MAX), 1'b0);
    text_q.push_back(8'hff);
    send_header('0, 1'b0);

    // Random part: mostly well-formed ranges, the rest noise and damage.
    random_base = chars_queued;
    headers     = 0;
    while (chars_queued - random_base < RANDOM_CHARS) begin
      len = pick_length();
      if ($urandom_range(0, 9) < 8) build_range(len);
      else build_broken(len);
      // Drain completely before some headers so the pipeline starts empty.
      send_header(len, headers % 30 == 0);
      headers++;
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (chars_pending.size() != 0 || hdr_ch.valid) @(posedge clk_i);
    while (verdicts_due.size() != 0) @(posedge clk_i);
    // Catch any stray verdict that trails the last expected one.
    repeat (16) @(posedge clk_i);

    if (verdicts_due.size() != 0)
      report($sformatf("%0d verdicts never arrived", verdicts_due.size()));
    if (errors == 0) begin
      $display("tb_http_byte_range_parser_unit: clean");
    end else begin
      $display("tb_http_byte_range_parser_unit: errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/brp_pkg.sv
rtl/brp_hdr_if.sv
rtl/brp_vrd_if.sv
rtl/brp_scan.sv
rtl/brp_judge.sv
rtl/http_byte_range_parser_unit.sv
rtl/brp_chk.sv
tb/tb_http_byte_range_parser_unit.sv
